### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the draw list block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ldl_pkg.sv
// ----------------------------------------------------------------------------
// ldl_pkg
// Constants, types and helpers of the layered draw list.
// ----------------------------------------------------------------------------
package ldl_pkg;

    localparam int NODE_CAP   = 4862;
    localparam int LAYERS     = 16;
    localparam int IDX_W      = $clog2(NODE_CAP + 1);
    localparam int ADDR_W     = $clog2(NODE_CAP);
    localparam int LAY_W      = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int INFO_W     = 10;
    localparam int PRIM_KINDS = 7;
    localparam int POOL_W     = 13;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [POOL_W-1:0] t_pool;

    localparam t_idx NIL = '1;

    localparam logic [1:0] OP_SUBMIT = 2'd0;
    localparam logic [1:0] OP_FLUSH  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [2:0] PRIM_LINE      = 3'd0;
    localparam logic [2:0] PRIM_TRI       = 3'd1;
    localparam logic [2:0] PRIM_QUAD      = 3'd2;
    localparam logic [2:0] PRIM_BLIT_SURF = 3'd3;
    localparam logic [2:0] PRIM_BLIT_BMP  = 3'd4;
    localparam logic [2:0] PRIM_VIEW3D    = 3'd5;
    localparam logic [2:0] PRIM_FULL      = 3'd6;
    localparam logic [2:0] PRIM_BAD       = 3'd7;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_LAYER = 3'd1;
    localparam logic [2:0] ST_LIST_FULL = 3'd2;
    localparam logic [2:0] ST_POOL_FULL = 3'd3;
    localparam logic [2:0] ST_BAD_SRC   = 3'd4;
    localparam logic [2:0] ST_BAD_DST   = 3'd5;

    typedef struct packed {
        logic [2:0]         prim;
        logic signed [7:0]  layer;
        logic signed [15:0] src_x0;
        logic signed [15:0] src_y0;
        logic signed [15:0] src_x1;
        logic signed [15:0] src_y1;
        logic signed [15:0] dst_x0;
        logic signed [15:0] dst_x1;
        logic               scene_valid;
    } t_sub;

    function automatic t_pool pool_cap(input logic [2:0] kind);
        unique case (kind)
            PRIM_LINE:      pool_cap = 13'd4096;
            PRIM_TRI:       pool_cap = 13'd200;
            PRIM_QUAD:      pool_cap = 13'd100;
            PRIM_BLIT_SURF: pool_cap = 13'd220;
            PRIM_BLIT_BMP:  pool_cap = 13'd220;
            PRIM_VIEW3D:    pool_cap = 13'd16;
            default:        pool_cap = '0;
        endcase
    endfunction

    function automatic logic [13:0] idx_out(input t_idx v);
        if (v == NIL) begin
            idx_out = '1;
        end else begin
            idx_out = 14'(v);
        end
    endfunction

endpackage

### rtl/ldl_ram.sv
// ----------------------------------------------------------------------------
// ldl_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ldl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/ldl_check.sv
// ----------------------------------------------------------------------------
// ldl_check
// Submit validation: layer range, list room, pool cap, rectangles, scene.
// ----------------------------------------------------------------------------
module ldl_check
    import ldl_pkg::*;
(
    input  t_sub       i_sub,
    input  logic       i_list_full,
    input  t_pool      i_pool_used,
    output logic [2:0] o_status
);

    logic bad_layer;

    assign bad_layer = i_sub.layer[7] || ({1'b0, i_sub.layer[6:0]} >= 8'(LAYERS));

    always_comb begin
        o_status = ST_OK;
        if (bad_layer) begin
            o_status = ST_BAD_LAYER;
        end else if (i_list_full) begin
            o_status = ST_LIST_FULL;
        end else if (i_sub.prim == PRIM_BAD) begin
            o_status = ST_POOL_FULL;
        end else if (i_sub.prim != PRIM_FULL) begin
            if (i_pool_used >= pool_cap(i_sub.prim)) begin
                o_status = ST_POOL_FULL;
            end else begin
                case (i_sub.prim) inside
                    PRIM_BLIT_SURF, PRIM_BLIT_BMP: begin
                        if ($signed(i_sub.src_x0) >= $signed(i_sub.src_x1) ||
                            $signed(i_sub.src_y0) >= $signed(i_sub.src_y1)) begin
                            o_status = ST_BAD_SRC;
                        end else if ($signed(i_sub.dst_x0) >= $signed(i_sub.dst_x1)) begin
                            o_status = ST_BAD_DST;
                        end
                    end
                    PRIM_VIEW3D: begin
                        if (!i_sub.scene_valid) begin
                            o_status = ST_BAD_SRC;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

### rtl/layered_draw_list_insert.sv
// ----------------------------------------------------------------------------
// layered_draw_list_insert
// Layer-ordered draw list kept as a linked node store in two RAMs.
//
// Input channel (i_valid / o_stall): one beat carries one command: submit,
// flush or read link. The block takes a beat only when idle; o_stall is high
// while a command is in work.
// Output channel (o_valid / i_stall): exactly one result beat per command,
// held in an output register, so the next command may start while a result
// waits.
// Paths: flush, refused submit, reads outside the list and the first node go
// straight to S_DONE; a link read passes S_RDLINK; a layer-cache hit passes
// S_HIT_RD and S_HIT_WR; a cache miss walks the chain in S_WALK one node per
// cycle through the link RAM read port, then passes S_FIX when the new node
// goes between two nodes.
// Reset clears head, count, layer cache and pool counters at once; the node
// RAMs are not cleared, only entries below the count are ever read.
// When the receiver stalls, the result holds and a finished command waits
// for the output register before the block goes idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module layered_draw_list_insert
    import ldl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_op,
    input  logic [2:0]         i_prim,
    input  logic signed [7:0]  i_layer,
    input  logic signed [15:0] i_src_x0,
    input  logic signed [15:0] i_src_y0,
    input  logic signed [15:0] i_src_x1,
    input  logic signed [15:0] i_src_y1,
    input  logic signed [15:0] i_dst_x0,
    input  logic signed [15:0] i_dst_x1,
    input  logic               i_scene_valid,
    input  logic [12:0]        i_node_sel,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_status,
    output logic signed [13:0] o_new_node,
    output logic signed [13:0] o_head_node,
    output logic signed [13:0] o_link_next,
    output logic [6:0]         o_link_layer,
    output logic [2:0]         o_link_prim,
    output logic [12:0]        o_node_count
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RDLINK = 3'd1;
    localparam logic [2:0] S_HIT_RD = 3'd2;
    localparam logic [2:0] S_HIT_WR = 3'd3;
    localparam logic [2:0] S_WALK   = 3'd4;
    localparam logic [2:0] S_FIX    = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    t_idx       r_cache [LAYERS];
    t_idx       n_cache [LAYERS];
    t_pool      r_pool [PRIM_KINDS];
    t_pool      n_pool [PRIM_KINDS];
    t_idx       r_head, n_head;
    t_idx       r_count, n_count;

    t_idx             r_self, n_self;
    logic [LAY_W-1:0] r_lay, n_lay;
    logic [6:0]       r_lay7, n_lay7;
    t_idx             r_cur, n_cur;
    t_idx             r_prev, n_prev;
    t_idx             r_c, n_c;
    logic [2:0]       r_status, n_status;
    logic [13:0]      r_new, n_new;
    logic [13:0]      r_lnext, n_lnext;
    logic [6:0]       r_llayer, n_llayer;
    logic [2:0]       r_lprim, n_lprim;

    logic [2:0]  r_o_status, n_o_status;
    logic [13:0] r_o_new, n_o_new;
    logic [13:0] r_o_head, n_o_head;
    logic [13:0] r_o_lnext, n_o_lnext;
    logic [6:0]  r_o_llayer, n_o_llayer;
    logic [2:0]  r_o_lprim, n_o_lprim;
    logic [12:0] r_o_count, n_o_count;

    t_sub             sub;
    logic [2:0]       chk_status;
    t_pool            pool_sel;
    logic [LAY_W-1:0] lay_idx;

    logic              nx_we;
    t_idx              nx_waddr;
    t_idx              nx_wdata;
    t_idx              nx_rdata;
    logic              in_we;
    logic [INFO_W-1:0] in_wdata;
    logic [INFO_W-1:0] in_rdata;
    t_idx              rd_addr;
    logic              walk_ge;

    assign sub = '{
        prim:        i_prim,
        layer:       i_layer,
        src_x0:      i_src_x0,
        src_y0:      i_src_y0,
        src_x1:      i_src_x1,
        src_y1:      i_src_y1,
        dst_x0:      i_dst_x0,
        dst_x1:      i_dst_x1,
        scene_valid: i_scene_valid
    };

    assign pool_sel = (i_prim == PRIM_BAD) ? '0 : r_pool[i_prim];
    assign lay_idx  = i_layer[LAY_W-1:0];

    ldl_check u_check (
        .i_sub       (sub),
        .i_list_full (r_count >= IDX_W'(NODE_CAP)),
        .i_pool_used (pool_sel),
        .o_status    (chk_status)
    );

    ldl_ram #(.WIDTH(IDX_W), .DEPTH(NODE_CAP)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_waddr (nx_waddr[ADDR_W-1:0]),
        .i_wdata (nx_wdata),
        .i_raddr (rd_addr[ADDR_W-1:0]),
        .o_rdata (nx_rdata)
    );

    ldl_ram #(.WIDTH(INFO_W), .DEPTH(NODE_CAP)) u_info_ram (
        .i_clk   (i_clk),
        .i_we    (in_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (in_wdata),
        .i_raddr (rd_addr[ADDR_W-1:0]),
        .o_rdata (in_rdata)
    );

    assign walk_ge = (in_rdata[INFO_W-1:3] >= r_lay7);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_cache     = r_cache;
        n_pool      = r_pool;
        n_head      = r_head;
        n_count     = r_count;
        n_self      = r_self;
        n_lay       = r_lay;
        n_lay7      = r_lay7;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_c         = r_c;
        n_status    = r_status;
        n_new       = r_new;
        n_lnext     = r_lnext;
        n_llayer    = r_llayer;
        n_lprim     = r_lprim;
        n_o_status  = r_o_status;
        n_o_new     = r_o_new;
        n_o_head    = r_o_head;
        n_o_lnext   = r_o_lnext;
        n_o_llayer  = r_o_llayer;
        n_o_lprim   = r_o_lprim;
        n_o_count   = r_o_count;
        nx_we       = 1'b0;
        nx_waddr    = r_self;
        nx_wdata    = NIL;
        in_we       = 1'b0;
        in_wdata    = {i_layer[6:0], i_prim};
        rd_addr     = r_cur;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_status = ST_OK;
                    n_new    = '1;
                    n_lnext  = '1;
                    n_llayer = '0;
                    n_lprim  = '0;
                    n_state  = S_DONE;
                    case (i_op)
                        OP_SUBMIT: begin
                            n_status = chk_status;
                            if (chk_status == ST_OK) begin
                                in_we    = 1'b1;
                                nx_we    = 1'b1;
                                nx_waddr = r_count;
                                nx_wdata = NIL;
                                n_self   = r_count;
                                n_lay    = lay_idx;
                                n_lay7   = i_layer[6:0];
                                n_new    = 14'(r_count);
                                n_count  = IDX_W'(r_count + 1'b1);
                                n_pool[i_prim] = POOL_W'(r_pool[i_prim] + 1'b1);
                                if (r_count == '0) begin
                                    n_head = '0;
                                end else if (r_cache[lay_idx] != NIL) begin
                                    rd_addr = r_cache[lay_idx];
                                    n_c     = r_cache[lay_idx];
                                    n_state = S_HIT_RD;
                                end else begin
                                    rd_addr = r_head;
                                    n_cur   = r_head;
                                    n_prev  = NIL;
                                    n_state = S_WALK;
                                end
                            end
                        end
                        OP_FLUSH: begin
                            for (int i = 0; i < LAYERS; i++) begin
                                n_cache[i] = NIL;
                            end
                            for (int i = 0; i < PRIM_KINDS; i++) begin
                                n_pool[i] = '0;
                            end
                            n_head  = NIL;
                            n_count = '0;
                        end
                        OP_READ: begin
                            if (14'(i_node_sel) < 14'(r_count)) begin
                                rd_addr = IDX_W'(i_node_sel);
                                n_state = S_RDLINK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RDLINK: begin
                n_lnext  = idx_out(nx_rdata);
                n_llayer = in_rdata[INFO_W-1:3];
                n_lprim  = in_rdata[2:0];
                n_state  = S_DONE;
            end
            S_HIT_RD: begin
                nx_we    = 1'b1;
                nx_waddr = r_self;
                nx_wdata = nx_rdata;
                n_state  = S_HIT_WR;
            end
            S_HIT_WR: begin
                nx_we    = 1'b1;
                nx_waddr = r_c;
                nx_wdata = r_self;
                n_state  = S_DONE;
            end
            S_WALK: begin
                if (nx_rdata != NIL && !walk_ge) begin
                    n_prev  = r_cur;
                    n_cur   = nx_rdata;
                    rd_addr = nx_rdata;
                end else begin
                    n_cache[r_lay] = r_self;
                    nx_we = 1'b1;
                    if (!walk_ge) begin
                        nx_waddr = r_cur;
                        nx_wdata = r_self;
                        n_state  = S_DONE;
                    end else if (r_prev == NIL) begin
                        nx_waddr = r_self;
                        nx_wdata = r_head;
                        n_head   = r_self;
                        n_state  = S_DONE;
                    end else begin
                        nx_waddr = r_self;
                        nx_wdata = r_cur;
                        n_state  = S_FIX;
                    end
                end
            end
            S_FIX: begin
                nx_we    = 1'b1;
                nx_waddr = r_prev;
                nx_wdata = r_self;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_new     = r_new;
                    n_o_head    = idx_out(r_head);
                    n_o_lnext   = r_lnext;
                    n_o_llayer  = r_llayer;
                    n_o_lprim   = r_lprim;
                    n_o_count   = 13'(r_count);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < LAYERS; i++) begin
                r_cache[i] <= NIL;
            end
            for (int i = 0; i < PRIM_KINDS; i++) begin
                r_pool[i] <= '0;
            end
            r_head  <= NIL;
            r_count <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cache     <= n_cache;
            r_pool      <= n_pool;
            r_head      <= n_head;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_self     <= n_self;
        r_lay      <= n_lay;
        r_lay7     <= n_lay7;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_c        <= n_c;
        r_status   <= n_status;
        r_new      <= n_new;
        r_lnext    <= n_lnext;
        r_llayer   <= n_llayer;
        r_lprim    <= n_lprim;
        r_o_status <= n_o_status;
        r_o_new    <= n_o_new;
        r_o_head   <= n_o_head;
        r_o_lnext  <= n_o_lnext;
        r_o_llayer <= n_o_llayer;
        r_o_lprim  <= n_o_lprim;
        r_o_count  <= n_o_count;
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_status     = r_o_status;
    assign o_new_node   = r_o_new;
    assign o_head_node  = r_o_head;
    assign o_link_next  = r_o_lnext;
    assign o_link_layer = r_o_llayer;
    assign o_link_prim  = r_o_lprim;
    assign o_node_count = r_o_count;

    `ASSERT_IMPL(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= IDX_W'(NODE_CAP), "count over cap")
    `ASSERT_NEXT(a_submit_count, i_clk, i_rst_n, r_state == S_IDLE && i_valid && i_op == OP_SUBMIT && chk_status == ST_OK, r_count == IDX_W'($past(r_count) + 1'b1), "count not advanced")
    `ASSERT_IMPL(a_head_empty, i_clk, i_rst_n, r_state == S_IDLE, (r_head == NIL) == (r_count == '0), "head and count disagree")
    `ASSERT_IMPL(a_walk_self, i_clk, i_rst_n, r_state == S_WALK, r_cur != r_self && r_prev != r_self, "walk reached new node")

endmodule
